// ===== design/pdm_pkg.sv =====
// pdm_pkg: shared constants, types and helper function of the pwm period/duty meter
// no dependencies; used by pdm_ctrl, pdm_datapath and pwm_period_duty_meter
`timescale 1ns / 1ps
`default_nettype none

package pdm_pkg;

   // capture counter and field widths
   localparam int COUNTER_WIDTH = 16;
   localparam int CAP_W         = 16;
   localparam int ELAPSED_W     = COUNTER_WIDTH + 1;
   localparam int TICK_W        = 27;
   localparam int FREQ_W        = 35;
   localparam int DUTY_W        = 15;
   localparam int Q8_SHIFT      = 8;

   // duty scale: 100 percent in q8
   localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(25600);
   localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(1000000);

   // shared serial divider: dividend width and step count
   localparam int NUM_W     = FREQ_W;
   localparam int PROD_W    = ELAPSED_W + DUTY_W;
   localparam int DIV_STEPS = NUM_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      PH_FIRST_RISE  = 2'd0,
      PH_FALL        = 2'd1,
      PH_SECOND_RISE = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      KIND_RISE = 3'b001,
      KIND_FALL = 3'b010,
      KIND_MEAS = 3'b100
   } kind_type;

   // controller to datapath
   typedef struct packed {
      logic     load_rise;
      logic     load_fall;
      logic     load_meas;
      logic     div_step;
      logic     freq_done;
      logic     duty_done;
      logic     emit;
      kind_type emit_kind;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic div_last;
      logic out_free;
   } status_type;

   // ticks from a to b modulo 2^COUNTER_WIDTH, equal values count as one full wrap
   function automatic logic [ELAPSED_W-1:0] elapsed(input logic [COUNTER_WIDTH-1:0] a,
                                                     input logic [COUNTER_WIDTH-1:0] b);
      logic [COUNTER_WIDTH-1:0] d;
      d = b - a;
      if (d == '0) begin
         elapsed = {1'b1, {COUNTER_WIDTH{1'b0}}};
      end else begin
         elapsed = {1'b0, d};
      end
   endfunction

endpackage

`default_nettype wire

// ===== design/pdm_ctrl.sv =====
// pdm_ctrl: edge phase tracking and sequencing of the shared divider
// depends on pdm_pkg
`timescale 1ns / 1ps
`default_nettype none

module pdm_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  pdm_pkg::status_type  status,
   output pdm_pkg::cmd_type     cmd
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_FREQ = 4'b0010,
      ST_DUTY = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   pdm_pkg::phase_type phase_ff, phase_in;
   pdm_pkg::kind_type  kind_ff, kind_in;

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      kind_in   = kind_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.emit_kind = kind_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (phase_ff)
                  pdm_pkg::PH_FALL: begin
                     cmd.load_fall = 1'b1;
                     kind_in       = pdm_pkg::KIND_FALL;
                     phase_in      = pdm_pkg::PH_SECOND_RISE;
                     state_in      = ST_EMIT;
                  end
                  pdm_pkg::PH_SECOND_RISE: begin
                     cmd.load_meas = 1'b1;
                     kind_in       = pdm_pkg::KIND_MEAS;
                     phase_in      = pdm_pkg::PH_FIRST_RISE;
                     state_in      = ST_FREQ;
                  end
                  default: begin
                     cmd.load_rise = 1'b1;
                     kind_in       = pdm_pkg::KIND_RISE;
                     phase_in      = pdm_pkg::PH_FALL;
                     state_in      = ST_EMIT;
                  end
               endcase
            end
         end
         ST_FREQ: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               cmd.freq_done = 1'b1;
               state_in      = ST_DUTY;
            end
         end
         ST_DUTY: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               cmd.duty_done = 1'b1;
               state_in      = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= pdm_pkg::PH_FIRST_RISE;
         kind_ff  <= pdm_pkg::KIND_RISE;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/pdm_datapath.sv =====
// pdm_datapath: capture registers, elapsed time, duty product, serial divider, result register
// depends on pdm_pkg
`timescale 1ns / 1ps
`default_nettype none

module pdm_datapath (
   input  wire                                clock,
   input  wire                                reset,
   input  wire  [pdm_pkg::CAP_W-1:0]          req_capture_value,
   input  wire                                csr_wr_en,
   input  wire  [pdm_pkg::TICK_W-1:0]         csr_wr_data,
   input  pdm_pkg::cmd_type                   cmd,
   output pdm_pkg::status_type                status,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic                               rsp_next_edge_falling,
   output logic                               rsp_measurement_valid,
   output logic [pdm_pkg::ELAPSED_W-1:0]      rsp_period_ticks,
   output logic [pdm_pkg::ELAPSED_W-1:0]      rsp_high_ticks,
   output logic [pdm_pkg::FREQ_W-1:0]         rsp_frequency_q8,
   output logic [pdm_pkg::DUTY_W-1:0]         rsp_duty_q8
);

   localparam int CW = pdm_pkg::COUNTER_WIDTH;
   localparam int EW = pdm_pkg::ELAPSED_W;
   localparam int NW = pdm_pkg::NUM_W;

   logic [pdm_pkg::TICK_W-1:0]    tick_ff;
   logic [CW-1:0]                 rise_ff, fall_ff;
   logic [EW-1:0]                 period_ff, high_ff;
   logic [pdm_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic [NW-1:0]                 num_ff, num_in;
   logic [EW-1:0]                 rem_ff, rem_in;
   logic [pdm_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [pdm_pkg::FREQ_W-1:0]    freq_ff;
   logic [pdm_pkg::DUTY_W-1:0]    duty_ff, duty_sat;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]                 cap;
   logic [EW:0]                   trial;
   logic                          quot_bit;
   logic [NW-1:0]                 step_num;
   logic [EW-1:0]                 step_rem;

   assign cap     = req_capture_value[CW-1:0];
   assign prod_in = pdm_pkg::PROD_W'(high_ff) * pdm_pkg::PROD_W'(pdm_pkg::DUTY_FULL);

   // one restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      trial    = {rem_ff, num_ff[NW-1]};
      quot_bit = (trial >= {1'b0, period_ff});
      if (quot_bit) begin
         step_rem = EW'(trial - {1'b0, period_ff});
      end else begin
         step_rem = trial[EW-1:0];
      end
      step_num = {num_ff[NW-2:0], quot_bit};
   end

   always_comb begin
      if (step_num > NW'(pdm_pkg::DUTY_FULL)) begin
         duty_sat = pdm_pkg::DUTY_FULL;
      end else begin
         duty_sat = step_num[pdm_pkg::DUTY_W-1:0];
      end
   end

   always_comb begin
      num_in = num_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (cmd.load_meas) begin
         num_in = {tick_ff, {pdm_pkg::Q8_SHIFT{1'b0}}};
         rem_in = '0;
         cnt_in = '0;
      end else if (cmd.freq_done) begin
         num_in = NW'(prod_ff);
         rem_in = '0;
         cnt_in = '0;
      end else if (cmd.div_step) begin
         num_in = step_num;
         rem_in = step_rem;
         cnt_in = cnt_ff + 1'b1;
      end
   end

   assign rsp_valid_in = cmd.emit | (rsp_valid_ff & ~rsp_ready);

   assign status.div_last = (cnt_ff == pdm_pkg::DIV_CNT_W'(pdm_pkg::DIV_STEPS - 1));
   assign status.out_free = ~rsp_valid_ff | rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= pdm_pkg::TICK_RESET;
         rise_ff      <= '0;
         fall_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         if (csr_wr_en) begin
            tick_ff <= csr_wr_data;
         end
         if (cmd.load_rise) begin
            rise_ff <= cap;
         end
         if (cmd.load_fall) begin
            fall_ff <= cap;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      prod_ff <= prod_in;
      if (cmd.load_meas) begin
         period_ff <= pdm_pkg::elapsed(rise_ff, cap);
         high_ff   <= pdm_pkg::elapsed(rise_ff, fall_ff);
      end
      if (cmd.freq_done) begin
         freq_ff <= step_num;
      end
      if (cmd.duty_done) begin
         duty_ff <= duty_sat;
      end
      if (cmd.emit) begin
         unique case (cmd.emit_kind)
            pdm_pkg::KIND_MEAS: begin
               rsp_next_edge_falling <= 1'b0;
               rsp_measurement_valid <= 1'b1;
               rsp_period_ticks      <= period_ff;
               rsp_high_ticks        <= high_ff;
               rsp_frequency_q8      <= freq_ff;
               rsp_duty_q8           <= duty_ff;
            end
            pdm_pkg::KIND_FALL: begin
               rsp_next_edge_falling <= 1'b0;
               rsp_measurement_valid <= 1'b0;
               rsp_period_ticks      <= '0;
               rsp_high_ticks        <= '0;
               rsp_frequency_q8      <= '0;
               rsp_duty_q8           <= '0;
            end
            default: begin
               rsp_next_edge_falling <= 1'b1;
               rsp_measurement_valid <= 1'b0;
               rsp_period_ticks      <= '0;
               rsp_high_ticks        <= '0;
               rsp_frequency_q8      <= '0;
               rsp_duty_q8           <= '0;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ===== design/pwm_period_duty_meter.sv =====
// pwm_period_duty_meter: top level of the pwm input-capture period and duty meter
// depends on pdm_pkg, pdm_ctrl and pdm_datapath
`timescale 1ns / 1ps
`default_nettype none

// Takes one capture counter value per detected input edge and walks three
// phases: first rising edge, falling edge, closing rising edge. Every edge
// gives exactly one result transfer; next_edge_falling tells the capture
// logic which polarity to arm next. The closing rising edge yields period
// and high time (modulo 2^16, equal captures count as 65536 ticks),
// frequency_q8 = floor(tick_rate_hz * 256 / period) and
// duty_q8 = floor(high * 25600 / period) saturated at 25600; the edge after
// it starts a fresh measurement. Sequencing: a first-rise or fall edge is
// accepted and then goes straight to loading the output register; a closing
// edge is accepted, then runs 35 steps for frequency and 35 steps for duty in
// one shared restoring divider, then loads the output register once it is free.
// One edge is in work at a time; the output register lets the next edge be
// accepted while the previous result still waits for rsp_ready.
// tick_rate_hz (reset 1000000) is written through csr_wr_en/csr_wr_data; the user
// must write it only while the block is idle, the block does not enforce this.

module pwm_period_duty_meter (
   input  wire                                clock,
   input  wire                                reset,
   // capture input channel
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire  [pdm_pkg::CAP_W-1:0]          req_capture_value,
   // result channel
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic                               rsp_next_edge_falling,
   output logic                               rsp_measurement_valid,
   output logic [pdm_pkg::ELAPSED_W-1:0]      rsp_period_ticks,
   output logic [pdm_pkg::ELAPSED_W-1:0]      rsp_high_ticks,
   output logic [pdm_pkg::FREQ_W-1:0]         rsp_frequency_q8,
   output logic [pdm_pkg::DUTY_W-1:0]         rsp_duty_q8,
   // tick rate register
   input  wire                                csr_wr_en,
   input  wire  [pdm_pkg::TICK_W-1:0]         csr_wr_data
);

   // command and status between sequencer and datapath
   pdm_pkg::cmd_type    cmd;
   pdm_pkg::status_type status;

   // phase tracking and divider sequencing
   pdm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // captures, elapsed ticks, shared divider and output register
   pdm_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .req_capture_value     (req_capture_value),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .cmd                   (cmd),
      .status                (status),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_next_edge_falling (rsp_next_edge_falling),
      .rsp_measurement_valid (rsp_measurement_valid),
      .rsp_period_ticks      (rsp_period_ticks),
      .rsp_high_ticks        (rsp_high_ticks),
      .rsp_frequency_q8      (rsp_frequency_q8),
      .rsp_duty_q8           (rsp_duty_q8)
   );

endmodule

`default_nettype wire
